/* rtl/mtg_pkg.sv */
package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FULL_IDX  = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W:0]   OFFS_SUM  = (IDX_W + 1)'(SHIFT_OFFSET);
  localparam logic [IDX_W:0]   WORDS_SUM = (IDX_W + 1)'(STATE_WORDS);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] SEED_MULT    = 32'd69069;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_SEED_LOAD,
    OP_SEED_STEP,
    OP_TW_INIT,
    OP_TW_LOAD,
    OP_TW_RD,
    OP_TW_WR,
    OP_DRAW_RD,
    OP_DRAW_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic idx_full;
  } status_t;

  function automatic logic [31:0] twist_word(logic [31:0] upper_src,
                                             logic [31:0] lower_src,
                                             logic [31:0] far_word);
    logic [31:0] y;
    logic [31:0] mag;
    y   = (upper_src & HIGH_BIT) | (lower_src & LOW_BITS);
    mag = y[0] ? TWIST_MATRIX : 32'd0;
    return far_word ^ (y >> 1) ^ mag;
  endfunction

  function automatic logic [31:0] temper(logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* rtl/mtg_ctrl.sv */
module mtg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             action_i,
  input  mtg_pkg::status_t status_i,
  output mtg_pkg::cmd_t    cmd_o,
  output logic             busy
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b0_0000_0001,
    S_IDLE     = 9'b0_0000_0010,
    S_SEED     = 9'b0_0000_0100,
    S_TW_LOAD  = 9'b0_0000_1000,
    S_TW_RD    = 9'b0_0001_0000,
    S_TW_WR    = 9'b0_0010_0000,
    S_DRAW_RD  = 9'b0_0100_0000,
    S_DRAW_OUT = 9'b0_1000_0000,
    S_SPARE    = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = mtg_pkg::OP_IDLE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = mtg_pkg::OP_CLEAR;
        if (status_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (action_i) begin
            cmd_o.op = mtg_pkg::OP_SEED_LOAD;
            state_d  = S_SEED;
          end else if (status_i.idx_full) begin
            cmd_o.op = mtg_pkg::OP_TW_INIT;
            state_d  = S_TW_LOAD;
          end else begin
            cmd_o.op = mtg_pkg::OP_DRAW_RD;
            state_d  = S_DRAW_OUT;
          end
        end
      end
      S_SEED: begin
        cmd_o.op = mtg_pkg::OP_SEED_STEP;
        if (status_i.cnt_last) state_d = S_IDLE;
      end
      S_TW_LOAD: begin
        cmd_o.op = mtg_pkg::OP_TW_LOAD;
        state_d  = S_TW_WR;
      end
      S_TW_RD: begin
        cmd_o.op = mtg_pkg::OP_TW_RD;
        state_d  = S_TW_WR;
      end
      S_TW_WR: begin
        cmd_o.op = mtg_pkg::OP_TW_WR;
        state_d  = status_i.cnt_last ? S_DRAW_RD : S_TW_RD;
      end
      S_DRAW_RD: begin
        cmd_o.op = mtg_pkg::OP_DRAW_RD;
        state_d  = S_DRAW_OUT;
      end
      S_DRAW_OUT: begin
        cmd_o.op = mtg_pkg::OP_DRAW_OUT;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // a seed or twist sweep ends only on the last table word
  a_seed_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEED && state_d == S_IDLE) |-> status_i.cnt_last)
    else $error("seed sweep ended early");

  a_tw_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TW_WR && state_d == S_DRAW_RD) |-> status_i.cnt_last)
    else $error("twist sweep ended early");

  a_draw_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW_OUT) |-> ($past(state_q) == S_DRAW_RD || $past(state_q) == S_IDLE))
    else $error("draw output without read");

endmodule

/* rtl/mtg_datapath.sv */
module mtg_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mtg_pkg::cmd_t    cmd_i,
  input  logic [31:0]      seed_i,
  output mtg_pkg::status_t status_o,
  output logic             valid_o,
  output logic [31:0]      value_o
);

  logic [31:0] mem [mtg_pkg::STATE_WORDS];

  mtg_pkg::idx_t cnt_q, cnt_d;
  mtg_pkg::idx_t idx_q, idx_d;
  logic [31:0]   w_q, w_d;
  logic [31:0]   cur_q, cur_d;
  logic [31:0]   value_q, value_d;
  logic          valid_q, valid_d;
  logic [31:0]   rdata_a_q, rdata_b_q;

  logic              we;
  mtg_pkg::idx_t     waddr, raddr_a, raddr_b;
  logic [31:0]       wdata;
  logic              cnt_last;
  mtg_pkg::idx_t     cnt_nxt;
  logic [mtg_pkg::IDX_W:0] far_sum;
  mtg_pkg::idx_t     far_idx;

  assign cnt_last = (cnt_q == mtg_pkg::LAST_IDX);
  assign cnt_nxt  = cnt_last ? '0 : cnt_q + 1'b1;
  assign far_sum  = {1'b0, cnt_q} + mtg_pkg::OFFS_SUM;
  assign far_idx  = (far_sum >= mtg_pkg::WORDS_SUM) ?
                    mtg_pkg::IDX_W'(far_sum - mtg_pkg::WORDS_SUM) :
                    far_sum[mtg_pkg::IDX_W-1:0];

  always_comb begin
    we      = 1'b0;
    waddr   = cnt_q;
    wdata   = '0;
    raddr_a = cnt_q;
    raddr_b = far_idx;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    w_d     = w_q;
    cur_d   = cur_q;
    value_d = value_q;
    valid_d = 1'b0;
    case (cmd_i.op)
      mtg_pkg::OP_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_nxt;
      end
      mtg_pkg::OP_SEED_LOAD: begin
        w_d   = seed_i;
        cnt_d = '0;
        idx_d = mtg_pkg::FULL_IDX;
      end
      mtg_pkg::OP_SEED_STEP: begin
        we    = 1'b1;
        wdata = w_q;
        w_d   = 32'(w_q * mtg_pkg::SEED_MULT);
        cnt_d = cnt_nxt;
      end
      mtg_pkg::OP_TW_INIT: begin
        raddr_a = '0;
        cnt_d   = '0;
      end
      mtg_pkg::OP_TW_LOAD: begin
        cur_d   = rdata_a_q;
        raddr_a = cnt_nxt;
      end
      mtg_pkg::OP_TW_RD: begin
        raddr_a = cnt_nxt;
      end
      mtg_pkg::OP_TW_WR: begin
        we    = 1'b1;
        wdata = mtg_pkg::twist_word(cur_q, rdata_a_q, rdata_b_q);
        cur_d = rdata_a_q;
        cnt_d = cnt_nxt;
        if (cnt_last) idx_d = '0;
      end
      mtg_pkg::OP_DRAW_RD: begin
        raddr_a = idx_q;
      end
      mtg_pkg::OP_DRAW_OUT: begin
        value_d = mtg_pkg::temper(rdata_a_q);
        valid_d = 1'b1;
        idx_d   = idx_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_q <= mem[raddr_a];
    rdata_b_q <= mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      idx_q   <= mtg_pkg::FULL_IDX;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    cur_q   <= cur_d;
    value_q <= value_d;
  end

  assign status_o.cnt_last = cnt_last;
  assign status_o.idx_full = (idx_q >= mtg_pkg::FULL_IDX);
  assign valid_o = valid_q;
  assign value_o = value_q;

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($past(cmd_i.op) == mtg_pkg::OP_DRAW_OUT))
    else $error("strobe without draw");

  a_seed_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mtg_pkg::OP_SEED_LOAD) |=> (idx_q == mtg_pkg::FULL_IDX && cnt_q == '0))
    else $error("reseed did not mark table exhausted");

  a_tw_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mtg_pkg::OP_TW_WR && cnt_last) |=> (idx_q == '0 && cnt_q == '0))
    else $error("twist end did not rewind index");

  a_draw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mtg_pkg::OP_DRAW_RD || cmd_i.op == mtg_pkg::OP_DRAW_OUT)
      |-> (idx_q < mtg_pkg::FULL_IDX))
    else $error("draw from exhausted table");

endmodule

/* rtl/mt19937_generator.sv */
// MT19937 pseudo-random generator, 624-word state in a two-read-port RAM.
// Command channel: a transfer happens at a rising edge with start high and
// busy low; action_i = 1 reseeds from seed_i, action_i = 0 draws a word.
// Result channel: valid_o is high for one cycle with value_o; there is no
// backpressure, the receiver must take it in that cycle.
// Draw with words left: the word is read at the transfer, tempered in
// S_DRAW_OUT and registered onto valid_o and value_o; busy is high only in
// S_DRAW_OUT, so the next command may be given while valid_o is high.
// Draw that finds the table used up: the twist sweeps the table one word at
// a time, a RAM read slot (S_TW_LOAD or S_TW_RD) then a write slot (S_TW_WR);
// then S_DRAW_RD and S_DRAW_OUT follow, with busy high throughout.
// Reseed: one table word written per cycle with busy high, no result.
// Reset: all 624 table words are cleared with busy high; the index starts
// exhausted, so draws before any reseed return zero.
module mt19937_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] seed_i,
  output logic        valid_o,
  output logic [31:0] value_o
);

  mtg_pkg::cmd_t    cmd;
  mtg_pkg::status_t status;

  mtg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  mtg_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .seed_i   (seed_i),
    .status_o (status),
    .valid_o  (valid_o),
    .value_o  (value_o)
  );

endmodule

/* bench/mt19937_generator_tb.sv */
module mt19937_generator_tb;

  localparam logic ACT_DRAW   = 1'b0;
  localparam logic ACT_RESEED = 1'b1;
  localparam int unsigned MAX_SHOWN = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        action_i;
  logic [31:0] seed_i;
  logic        valid_o;
  logic [31:0] value_o;

  logic [31:0] mt_words[mtg_pkg::STATE_WORDS];
  int unsigned mt_pos;
  logic [31:0] expected_values[$];
  int unsigned mismatch_cnt;
  bit          gaps_on;

  mt19937_generator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .action_i(action_i),
    .seed_i  (seed_i),
    .valid_o (valid_o),
    .value_o (value_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] tempered(input logic [31:0] raw);
    logic [31:0] y;
    y = raw ^ (raw >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
    return y ^ (y >> 18);
  endfunction

  task automatic twist_table();
    logic [31:0] y;
    for (int i = 0; i < mtg_pkg::STATE_WORDS; i++) begin
      y = {mt_words[i][31], mt_words[(i + 1) % mtg_pkg::STATE_WORDS][30:0]};
      mt_words[i] = mt_words[(i + mtg_pkg::SHIFT_OFFSET) % mtg_pkg::STATE_WORDS]
                    ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
    end
  endtask

  task automatic predict_cmd(input logic act, input logic [31:0] sd);
    if (act == ACT_RESEED) begin
      mt_words[0] = sd;
      for (int i = 1; i < mtg_pkg::STATE_WORDS; i++)
        mt_words[i] = mtg_pkg::SEED_MULT * mt_words[i - 1];
      mt_pos = mtg_pkg::STATE_WORDS;
    end else begin
      if (mt_pos >= mtg_pkg::STATE_WORDS) begin
        twist_table();
        mt_pos = 0;
      end
      expected_values.push_back(tempered(mt_words[mt_pos]));
      mt_pos = mt_pos + 1;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // result checker; no backpressure, so every strobe is a transfer
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && valid_o) begin
      if (expected_values.size() == 0) begin
        note_mismatch($sformatf("unexpected value %08h", value_o));
      end else begin
        want = expected_values.pop_front();
        if (value_o !== want)
          note_mismatch($sformatf("value exp %08h got %08h", want, value_o));
      end
    end
  end

  task automatic hold_off(input int unsigned n);
    @(negedge clk_i);
    start    <= 1'b0;
    action_i <= 1'($urandom);
    seed_i   <= $urandom;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_cmd(input logic act, input logic [31:0] sd);
    if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 14));
    @(negedge clk_i);
    start    <= 1'b1;
    action_i <= act;
    seed_i   <= sd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_cmd(act, sd);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_unseeded_draws();
    send_cmd(ACT_DRAW, 32'hffff_ffff);
    send_cmd(ACT_DRAW, 32'd0);
    send_cmd(ACT_DRAW, $urandom);
  endtask

  task automatic test_zero_seed();
    send_cmd(ACT_RESEED, 32'd0);
    send_cmd(ACT_DRAW, $urandom);
    send_cmd(ACT_DRAW, $urandom);
  endtask

  task automatic test_seed_extremes();
    send_cmd(ACT_RESEED, 32'hffff_ffff);
    send_cmd(ACT_DRAW, 32'd0);
    send_cmd(ACT_DRAW, 32'hffff_ffff);
    wait_drained();
    send_cmd(ACT_RESEED, 32'd1);
    send_cmd(ACT_DRAW, $urandom);
    send_cmd(ACT_RESEED, 32'h8000_0000);
    send_cmd(ACT_DRAW, $urandom);
    send_cmd(ACT_RESEED, 32'd5489);
    send_cmd(ACT_DRAW, $urandom);
    send_cmd(ACT_DRAW, $urandom);
    // back-to-back reseeds: only the second one counts
    send_cmd(ACT_RESEED, 32'haaaa_aaaa);
    send_cmd(ACT_RESEED, 32'h5555_5555);
    send_cmd(ACT_DRAW, $urandom);
  endtask

  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned run;
    sent = 0;
    while (sent < 20) begin
      case ($urandom_range(0, 9))
        0: begin
          send_cmd(ACT_RESEED, pick_seed());
          send_cmd(ACT_RESEED, pick_seed());
          sent += 2;
        end
        1: begin
          run = $urandom_range(1, 6);
          repeat (run) send_cmd(ACT_DRAW, $urandom);
          sent += run;
        end
        default: begin
          run = $urandom_range(1, 40);
          send_cmd(ACT_RESEED, pick_seed());
          repeat (run) send_cmd(ACT_DRAW, $urandom);
          sent += run + 1;
        end
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // runs past the end of the table, so the twist happens twice on one seed
  task automatic test_index_wrap();
    send_cmd(ACT_RESEED, $urandom);
    repeat (mtg_pkg::STATE_WORDS - 100) send_cmd(ACT_DRAW, $urandom);
    gaps_on = 1'b0;
    repeat (102) send_cmd(ACT_DRAW, $urandom);
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = ACT_DRAW;
    seed_i       = 32'd0;
    mismatch_cnt = 0;
    gaps_on      = 1'b1;
    for (int i = 0; i < mtg_pkg::STATE_WORDS; i++) mt_words[i] = 32'd0;
    mt_pos = mtg_pkg::STATE_WORDS;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unseeded_draws();
    test_zero_seed();
    test_seed_extremes();
    test_random_sequences();
    test_index_wrap();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_values.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout, %0d values still expected", expected_values.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/mtg_pkg.sv
rtl/mtg_ctrl.sv
rtl/mtg_datapath.sv
rtl/mt19937_generator.sv
bench/mt19937_generator_tb.sv
